// ===== rtl/prit_pkg.sv =====
// Package for the pending request id table: field widths, opcodes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package prit_pkg;

    localparam int unsigned OPCODE_W     = 2;
    localparam int unsigned ID_W         = 32;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned SHARE_W      = 64;
    localparam int unsigned SLOT_COUNT   = 8;
    localparam int unsigned PAYLOAD_BITS = 64;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUBMIT = 3'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_TAKE     = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // capture request fields
        logic clear_all;     // empty every slot
        logic idx_clear;     // restart scan at slot 0
        logic idx_inc;       // step scan to next slot
        logic write_slot;    // write request into scanned slot
        logic free_slot;     // drop valid mark of scanned slot
        logic shift;         // shift slots down, request into last slot
        logic load_result;   // load output register
        logic result_found;  // result is a hit on the scanned slot
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_empty;
        logic slot_match;
        logic last_slot;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/prit_req_if.sv =====
// Request channel interface: valid/ready handshake plus request fields.
// Depends on prit_pkg for field widths.
interface prit_req_if;
    logic                               valid;
    logic                               ready;
    logic [prit_pkg::OPCODE_W-1:0]      opcode;
    logic signed [prit_pkg::ID_W-1:0]   request_id;
    logic [prit_pkg::KIND_W-1:0]        request_kind;
    logic [prit_pkg::SHARE_W-1:0]       share_payload;

    modport source (output valid, opcode, request_id, request_kind, share_payload,
                    input ready);
    modport sink   (input valid, opcode, request_id, request_kind, share_payload,
                    output ready);
endinterface

// ===== rtl/prit_rsp_if.sv =====
// Response channel interface: valid/ready handshake plus take result fields.
// Depends on prit_pkg for field widths.
interface prit_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [prit_pkg::KIND_W-1:0]   taken_kind;
    logic [prit_pkg::SHARE_W-1:0]  taken_payload;

    modport source (output valid, found, taken_kind, taken_payload, input ready);
    modport sink   (input valid, found, taken_kind, taken_payload, output ready);
endinterface

// ===== rtl/prit_datapath.sv =====
// Datapath: slot registers, scan index, request capture and result register.
// Depends on prit_pkg and prit_rsp_if.
module prit_datapath #(
    parameter int unsigned SLOT_COUNT   = prit_pkg::SLOT_COUNT,
    parameter int unsigned PAYLOAD_BITS = prit_pkg::PAYLOAD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [prit_pkg::ID_W-1:0]  request_id,
    input  logic [prit_pkg::KIND_W-1:0]       request_kind,
    input  logic [prit_pkg::SHARE_W-1:0]      share_payload,
    input  prit_pkg::cmd_t                    cmd,
    output prit_pkg::status_t                 sts,
    prit_rsp_if.source                        rsp
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    logic [prit_pkg::ID_W-1:0]      id_reg;
    logic [prit_pkg::KIND_W-1:0]    kind_reg;
    logic [PAYLOAD_BITS-1:0]        pay_reg;
    logic [IDX_W-1:0]               idx_reg, idx_next;

    logic [SLOT_COUNT-1:0]          valid_reg, valid_next;
    logic [prit_pkg::ID_W-1:0]      slot_id_reg   [SLOT_COUNT];
    logic [prit_pkg::KIND_W-1:0]    slot_kind_reg [SLOT_COUNT];
    logic [PAYLOAD_BITS-1:0]        slot_pay_reg  [SLOT_COUNT];

    logic                           out_valid_reg, out_valid_next;
    logic                           out_found_reg;
    logic [prit_pkg::KIND_W-1:0]    out_kind_reg;
    logic [prit_pkg::SHARE_W-1:0]   out_share_reg;

    logic [prit_pkg::KIND_W-1:0]    cur_kind;

    // request capture; non-submit payload is stored as zero
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg   <= request_id;
            kind_reg <= request_kind;
            pay_reg  <= (request_kind == prit_pkg::KIND_SUBMIT)
                        ? share_payload[PAYLOAD_BITS-1:0] : '0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear_all)
            valid_next = '0;
        else if (cmd.shift)
            valid_next = {1'b1, valid_reg[SLOT_COUNT-1:1]};
        else if (cmd.write_slot)
            valid_next[idx_reg] = 1'b1;
        else if (cmd.free_slot)
            valid_next[idx_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // slot contents: shift line, plus a write at the scan index
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int i = 0; i < SLOT_COUNT - 1; i++)
            begin
                slot_id_reg[i]   <= slot_id_reg[i+1];
                slot_kind_reg[i] <= slot_kind_reg[i+1];
                slot_pay_reg[i]  <= slot_pay_reg[i+1];
            end
            slot_id_reg[SLOT_COUNT-1]   <= id_reg;
            slot_kind_reg[SLOT_COUNT-1] <= kind_reg;
            slot_pay_reg[SLOT_COUNT-1]  <= pay_reg;
        end
        else if (cmd.write_slot)
        begin
            slot_id_reg[idx_reg]   <= id_reg;
            slot_kind_reg[idx_reg] <= kind_reg;
            slot_pay_reg[idx_reg]  <= pay_reg;
        end
    end

    assign cur_kind = slot_kind_reg[idx_reg];

    always_comb
    begin
        sts.slot_empty = !valid_reg[idx_reg];
        sts.slot_match = valid_reg[idx_reg] && (slot_id_reg[idx_reg] == id_reg);
        sts.last_slot  = (idx_reg == LAST_IDX);
        sts.out_free   = !out_valid_reg || rsp.ready;
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_found_reg <= cmd.result_found;
            out_kind_reg  <= cmd.result_found ? cur_kind : prit_pkg::KIND_NONE;
            out_share_reg <= (cmd.result_found && cur_kind == prit_pkg::KIND_SUBMIT)
                             ? prit_pkg::SHARE_W'(slot_pay_reg[idx_reg]) : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.taken_kind    = out_kind_reg;
    assign rsp.taken_payload = out_share_reg;

endmodule

// ===== rtl/prit_controller.sv =====
// Controller FSM: accepts requests, sequences the slot scan, shift and result.
// Depends on prit_pkg.
module prit_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [prit_pkg::OPCODE_W-1:0]   in_opcode,
    output logic                            in_ready,
    input  prit_pkg::status_t               sts,
    output prit_pkg::cmd_t                  cmd
);

    prit_pkg::state_t state_reg, state_next;
    logic             take_reg, take_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prit_pkg::ST_IDLE;
            take_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            take_reg  <= take_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        take_next  = take_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            prit_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (prit_pkg::op_t'(in_opcode))
                        prit_pkg::OP_REGISTER:
                        begin
                            cmd.idx_clear = 1'b1;
                            take_next     = 1'b0;
                            state_next    = prit_pkg::ST_SCAN;
                        end
                        prit_pkg::OP_TAKE:
                        begin
                            cmd.idx_clear = 1'b1;
                            take_next     = 1'b1;
                            state_next    = prit_pkg::ST_SCAN;
                        end
                        prit_pkg::OP_CLEAR:
                            cmd.clear_all = 1'b1;
                        default:
                            ;
                    endcase
                end
            end
            prit_pkg::ST_SCAN:
            begin
                if (!take_reg)
                begin
                    if (sts.slot_empty)
                    begin
                        cmd.write_slot = 1'b1;
                        state_next     = prit_pkg::ST_IDLE;
                    end
                    else if (sts.last_slot)
                        state_next = prit_pkg::ST_SHIFT;
                    else
                        cmd.idx_inc = 1'b1;
                end
                else
                begin
                    if (sts.slot_match || sts.last_slot)
                    begin
                        // hold on the slot until the result register is free
                        if (sts.out_free)
                        begin
                            cmd.load_result  = 1'b1;
                            cmd.result_found = sts.slot_match;
                            cmd.free_slot    = sts.slot_match;
                            state_next       = prit_pkg::ST_IDLE;
                        end
                    end
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            prit_pkg::ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = prit_pkg::ST_IDLE;
            end
            default:
                state_next = prit_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/pending_request_id_table.sv =====
// Top level of the pending request id table: controller plus slot datapath.
// Depends on prit_pkg, prit_req_if, prit_rsp_if, prit_controller, prit_datapath.
//
//  channel | modport | transaction carries
//  --------+---------+---------------------------------------------------
//  req     | sink    | opcode, request_id, request_kind, share_payload
//  rsp     | source  | found, taken_kind, taken_payload (take only)
//
// One request at a time; req.ready is high only while the controller idles.
// A clear or an unused opcode ends on acceptance; a register scans the slots
// from slot 0, one a cycle, and fills the first empty one, or shifts the slots
// down when all are full; a take scans likewise to a match or the last slot.
// The result register parts the sides: a take that finishes while rsp stalls
// waits on its slot until the register frees. Reset empties every slot at once.
module pending_request_id_table #(
    parameter int unsigned SLOT_COUNT   = prit_pkg::SLOT_COUNT,
    parameter int unsigned PAYLOAD_BITS = prit_pkg::PAYLOAD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    prit_req_if.sink    req,
    prit_rsp_if.source  rsp
);

    prit_pkg::cmd_t    cmd;
    prit_pkg::status_t sts;
    logic              in_ready;

    assign req.ready = in_ready;

    // sequencing of scan, shift and result load
    prit_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot storage and result register
    prit_datapath #(
        .SLOT_COUNT   (SLOT_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_id    (req.request_id),
        .request_kind  (req.request_kind),
        .share_payload (req.share_payload),
        .cmd           (cmd),
        .sts           (sts),
        .rsp           (rsp)
    );

`ifndef SYNTHESIS
    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> sts.out_free)
        else $error("result loaded while output register busy");

    // only a matching slot is ever freed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_slot |-> (sts.slot_match && cmd.load_result))
        else $error("slot freed without a match");

    // a registration only fills an empty slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_slot |-> sts.slot_empty)
        else $error("registration overwrote a valid slot");

    // no new request is taken in the cycle after one starts a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_clear |=> !req.ready)
        else $error("request accepted during scan");
`endif

endmodule
